/* rtl/core/uart_frame_parser_top_macros.svh */
// Assertion helpers for the frame parser.
`ifndef UART_FRAME_PARSER_TOP_MACROS_SVH
`define UART_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ufp_pkg.sv */
package ufp_pkg;

    localparam logic [7:0] HDR1 = 8'hAA;
    localparam logic [7:0] HDR2 = 8'h55;

    localparam logic [2:0] ID_BYTES_STD = 3'd2;
    localparam logic [2:0] ID_BYTES_EXT = 3'd4;
    localparam logic [2:0] ID_BYTES_ONE = 3'd1;

    typedef enum logic [1:0] {
        REG_MAX_CONTROL = 2'd0,
        REG_STD_CAN     = 2'd1,
        REG_EXT_CAN     = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_CTRL,
        PH_CMD,
        PH_BODY,
        PH_SUM
    } phase_t;

    typedef enum logic [1:0] {
        TOK_CTRL,
        TOK_CMD,
        TOK_BODY,
        TOK_SUM
    } tok_kind_t;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
        logic [2:0] index;
        logic [2:0] id_bytes;
        logic [3:0] length;
    } tok_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  control_code;
        logic [31:0] command_code;
        logic [2:0]  command_bytes;
        logic [3:0]  body_length;
        logic [63:0] body_bytes;
        logic [7:0]  got_checksum;
        logic [7:0]  calc_checksum;
    } result_t;

endpackage

/* rtl/core/ufp_fifo.sv */
// Small register FIFO; DEPTH must be a power of two, at least 2.
module ufp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

/* rtl/core/ufp_front.sv */
// Header hunt, length and control id checks; emits one token per control, command, body and checksum byte.
module ufp_front #(
    parameter int MAX_BODY = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    rx_byte,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          tok_full,
    output logic          full,
    output logic          tok_push,
    output ufp_pkg::tok_t tok
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_BODY);

    ufp_pkg::phase_t phase_reg, phase_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] need_reg, need_next;
    logic [3:0] len_reg, len_next;
    logic [7:0] max_ctrl_reg;
    logic [7:0] std_code_reg;
    logic [7:0] ext_code_reg;
    logic       accept;
    logic [3:0] cnt_inc;

    assign full    = tok_full;
    assign accept  = push && !tok_full;
    assign cnt_inc = cnt_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ctrl_reg <= 8'd15;
            std_code_reg <= 8'd0;
            ext_code_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ufp_pkg::REG_MAX_CONTROL: max_ctrl_reg <= cfg_data;
                ufp_pkg::REG_STD_CAN:     std_code_reg <= cfg_data;
                ufp_pkg::REG_EXT_CAN:     ext_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ufp_pkg::PH_HUNT1;
            cnt_reg   <= '0;
            need_reg  <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            need_reg  <= need_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        need_next    = need_reg;
        len_next     = len_reg;
        tok_push     = 1'b0;
        tok.kind     = ufp_pkg::TOK_CTRL;
        tok.data     = rx_byte;
        tok.index    = cnt_reg[2:0];
        tok.id_bytes = need_reg;
        tok.length   = len_reg;

        unique case (phase_reg)
            ufp_pkg::PH_HUNT1:
            begin
                if (rx_byte == ufp_pkg::HDR1)
                    phase_next = ufp_pkg::PH_HUNT2;
            end
            ufp_pkg::PH_HUNT2:
            begin
                if (rx_byte == ufp_pkg::HDR2)
                    phase_next = ufp_pkg::PH_LEN;
                else
                    phase_next = ufp_pkg::PH_HUNT1;
            end
            ufp_pkg::PH_LEN:
            begin
                if (rx_byte >= 8'd1 && rx_byte <= MAX_LEN)
                begin
                    len_next   = rx_byte[3:0];
                    phase_next = ufp_pkg::PH_CTRL;
                end
                else
                    phase_next = ufp_pkg::PH_HUNT1;
            end
            ufp_pkg::PH_CTRL:
            begin
                if (rx_byte <= max_ctrl_reg)
                begin
                    // standard code wins when both codes are equal
                    if (rx_byte == std_code_reg)
                        need_next = ufp_pkg::ID_BYTES_STD;
                    else if (rx_byte == ext_code_reg)
                        need_next = ufp_pkg::ID_BYTES_EXT;
                    else
                        need_next = ufp_pkg::ID_BYTES_ONE;
                    cnt_next   = '0;
                    tok_push   = accept;
                    tok.kind   = ufp_pkg::TOK_CTRL;
                    phase_next = ufp_pkg::PH_CMD;
                end
                else
                    phase_next = ufp_pkg::PH_HUNT1;
            end
            ufp_pkg::PH_CMD:
            begin
                tok_push = accept;
                tok.kind = ufp_pkg::TOK_CMD;
                cnt_next = cnt_inc;
                if (cnt_inc >= {1'b0, need_reg})
                begin
                    cnt_next   = '0;
                    phase_next = ufp_pkg::PH_BODY;
                end
            end
            ufp_pkg::PH_BODY:
            begin
                tok_push = accept;
                tok.kind = ufp_pkg::TOK_BODY;
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg)
                begin
                    cnt_next   = '0;
                    phase_next = ufp_pkg::PH_SUM;
                end
            end
            ufp_pkg::PH_SUM:
            begin
                tok_push   = accept;
                tok.kind   = ufp_pkg::TOK_SUM;
                phase_next = ufp_pkg::PH_HUNT1;
            end
            default:
                phase_next = ufp_pkg::PH_HUNT1;
        endcase

        if (phase_next == ufp_pkg::PH_HUNT1)
        begin
            cnt_next  = '0;
            need_next = '0;
            len_next  = '0;
        end
    end

endmodule

/* rtl/core/ufp_back.sv */
// Collects control, command and body bytes, keeps the running sum,
// and builds the result on the checksum token.
module ufp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tok_empty,
    input  ufp_pkg::tok_t    tok,
    output logic             tok_pop,
    input  logic             res_full,
    output logic             res_push,
    output ufp_pkg::result_t res
);

    logic [7:0]  control_reg, control_next;
    logic [31:0] command_reg, command_next;
    logic [63:0] body_reg, body_next;
    logic [7:0]  sum_reg, sum_next;
    logic [5:0]  body_base;

    assign body_base = {tok.index, 3'b000};

    // a checksum token waits until the result queue has room
    assign tok_pop  = !tok_empty && (tok.kind != ufp_pkg::TOK_SUM || !res_full);
    assign res_push = tok_pop && (tok.kind == ufp_pkg::TOK_SUM);

    assign res.status        = (tok.data != sum_reg);
    assign res.control_code  = control_reg;
    assign res.command_code  = command_reg;
    assign res.command_bytes = tok.id_bytes;
    assign res.body_length   = tok.length;
    assign res.body_bytes    = body_reg;
    assign res.got_checksum  = tok.data;
    assign res.calc_checksum = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            command_reg <= '0;
            body_reg    <= '0;
            sum_reg     <= '0;
        end
        else if (tok_pop)
        begin
            control_reg <= control_next;
            command_reg <= command_next;
            body_reg    <= body_next;
            sum_reg     <= sum_next;
        end
    end

    always_comb
    begin
        control_next = control_reg;
        command_next = command_reg;
        body_next    = body_reg;
        sum_next     = sum_reg;
        unique case (tok.kind)
            ufp_pkg::TOK_CTRL:
            begin
                control_next = tok.data;
                sum_next     = tok.data;
                command_next = '0;
                body_next    = '0;
            end
            ufp_pkg::TOK_CMD:
            begin
                command_next = {command_reg[23:0], tok.data};
                sum_next     = sum_reg + tok.data;
            end
            ufp_pkg::TOK_BODY:
            begin
                body_next[body_base +: 8] = tok.data;
                sum_next                  = sum_reg + tok.data;
            end
            ufp_pkg::TOK_SUM: ;
            default: ;
        endcase
    end

endmodule

/* rtl/core/uart_frame_parser_top.sv */
// A MID_DEPTH token queue separates front and back; the result queue follows.
// Throughput: one byte per cycle while the token queue has room, set by
// the front state update and the 8-bit running-sum add in the back.
// Reset: async active low; hunts for the first header byte, registers take
// their default values, both queues empty. No clearing pass.
`include "uart_frame_parser_top_macros.svh"

module uart_frame_parser_top #(
    parameter int MAX_BODY  = 8,
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic        status,
    output logic [7:0]  control_code,
    output logic [31:0] command_code,
    output logic [2:0]  command_bytes,
    output logic [3:0]  body_length,
    output logic [63:0] body_bytes,
    output logic [7:0]  got_checksum,
    output logic [7:0]  calc_checksum
);

    localparam int TOK_W = $bits(ufp_pkg::tok_t);
    localparam int RES_W = $bits(ufp_pkg::result_t);

    ufp_pkg::tok_t    front_tok;
    ufp_pkg::tok_t    back_tok;
    ufp_pkg::result_t back_res;
    ufp_pkg::result_t out_res;
    logic             tok_push;
    logic             tok_pop;
    logic             tok_full;
    logic             tok_empty;
    logic             res_push;
    logic             res_full;
    logic [TOK_W-1:0] tok_rdata;
    logic [RES_W-1:0] res_rdata;

    ufp_front #(
        .MAX_BODY (MAX_BODY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tok_full  (tok_full),
        .full      (full),
        .tok_push  (tok_push),
        .tok       (front_tok)
    );

    ufp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (MID_DEPTH)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .wdata (front_tok),
        .pop   (tok_pop),
        .rdata (tok_rdata),
        .full  (tok_full),
        .empty (tok_empty)
    );

    assign back_tok = ufp_pkg::tok_t'(tok_rdata);

    ufp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_empty (tok_empty),
        .tok       (back_tok),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    ufp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .pop   (pop),
        .rdata (res_rdata),
        .full  (res_full),
        .empty (empty)
    );

    assign out_res       = ufp_pkg::result_t'(res_rdata);
    assign status        = out_res.status;
    assign control_code  = out_res.control_code;
    assign command_code  = out_res.command_code;
    assign command_bytes = out_res.command_bytes;
    assign body_length   = out_res.body_length;
    assign body_bytes    = out_res.body_bytes;
    assign got_checksum  = out_res.got_checksum;
    assign calc_checksum = out_res.calc_checksum;

    `UFP_ASSERT_NOW(a_status_match, clk, rst_n, !empty, status == (got_checksum != calc_checksum), "status disagrees with checksums")
    `UFP_ASSERT_NOW(a_cmd_bytes, clk, rst_n, !empty, command_bytes == 3'd1 || command_bytes == 3'd2 || command_bytes == 3'd4, "bad command byte count")
    `UFP_ASSERT_NOW(a_body_len, clk, rst_n, !empty, body_length >= 4'd1 && body_length <= 4'(MAX_BODY), "body length out of range")
    `UFP_ASSERT_NEXT(a_tok_hold, clk, rst_n, !tok_empty && !tok_pop, !tok_empty && $stable(tok_rdata), "stalled token changed")

endmodule

/* tb/uart_frame_parser_top_tb.sv */
`timescale 1ns / 100ps

module uart_frame_parser_top_tb;

    localparam real CLK_PERIOD    = 4.0;
    localparam int  MAX_BODY      = 8;
    localparam int  SETTLE_CYCLES = 8;       // block latency plus mid queue, with margin
    localparam int  STALL_CYCLES  = 300;
    localparam int  TAIL_CYCLES   = 20;
    localparam int  TIMEOUT_NS    = 2000000;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        LINK_BYTE,
        LINK_CFG,
        LINK_DRAIN,
        LINK_STALL
    } link_op_t;

    typedef struct packed {
        link_op_t   op;
        logic [7:0] data;
        logic [1:0] idx;
    } link_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  rx_byte;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        empty;
    logic        pop;
    logic        status;
    logic [7:0]  control_code;
    logic [31:0] command_code;
    logic [2:0]  command_bytes;
    logic [3:0]  body_length;
    logic [63:0] body_bytes;
    logic [7:0]  got_checksum;
    logic [7:0]  calc_checksum;

    uart_frame_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .control_code (control_code),
        .command_code (command_code),
        .command_bytes(command_bytes),
        .body_length  (body_length),
        .body_bytes   (body_bytes),
        .got_checksum (got_checksum),
        .calc_checksum(calc_checksum)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // stimulus and expectations
    link_item_t        link_ops[$];
    ufp_pkg::result_t  frames_due[$];

    int  cyc        = 0;
    int  quiet      = 0;
    int  mismatches = 0;
    int  byte_total = 0;
    bit  in_taken   = 1'b0;
    bit  stall_req  = 1'b0;
    bit  stall_done = 1'b0;
    int  stall_left = 0;

    // register values as planned by the generator
    logic [7:0] plan_max = 8'd15;
    logic [7:0] plan_std = 8'd0;
    logic [7:0] plan_ext = 8'd1;

    // parser copy: registers
    logic [7:0] cfg_max = 8'd15;
    logic [7:0] cfg_std = 8'd0;
    logic [7:0] cfg_ext = 8'd1;

    // parser copy: frame state
    ufp_pkg::phase_t ph     = ufp_pkg::PH_HUNT1;
    logic [3:0]      cnt_h  = '0;
    logic [2:0]      need_h = '0;
    logic [3:0]      len_h  = '0;
    logic [7:0]      ctrl_h = '0;
    logic [31:0]     cmd_h  = '0;
    logic [63:0]     body_h = '0;
    logic [7:0]      sum_h  = '0;

    function automatic bit no_idle();
        return (cyc >= 400) && (cyc < 900);
    endfunction

    task automatic clear_frame();
        ph     = ufp_pkg::PH_HUNT1;
        cnt_h  = '0;
        need_h = '0;
        len_h  = '0;
        ctrl_h = '0;
        cmd_h  = '0;
        body_h = '0;
        sum_h  = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        ufp_pkg::result_t r;
        case (ph)
            ufp_pkg::PH_HUNT1:
                if (b == ufp_pkg::HDR1)
                    ph = ufp_pkg::PH_HUNT2;
            ufp_pkg::PH_HUNT2:
                if (b == ufp_pkg::HDR2)
                    ph = ufp_pkg::PH_LEN;
                else
                    clear_frame();
            ufp_pkg::PH_LEN:
                if (b >= 8'd1 && b <= 8'(MAX_BODY))
                begin
                    len_h = b[3:0];
                    ph    = ufp_pkg::PH_CTRL;
                end
                else
                    clear_frame();
            ufp_pkg::PH_CTRL:
                if (b <= cfg_max)
                begin
                    ctrl_h = b;
                    sum_h  = b;
                    if (b == cfg_std)
                        need_h = ufp_pkg::ID_BYTES_STD;
                    else if (b == cfg_ext)
                        need_h = ufp_pkg::ID_BYTES_EXT;
                    else
                        need_h = ufp_pkg::ID_BYTES_ONE;
                    cnt_h = '0;
                    cmd_h = '0;
                    ph    = ufp_pkg::PH_CMD;
                end
                else
                    clear_frame();
            ufp_pkg::PH_CMD:
            begin
                cmd_h = {cmd_h[23:0], b};
                sum_h = sum_h + b;
                cnt_h = cnt_h + 4'd1;
                if (cnt_h >= {1'b0, need_h})
                begin
                    cnt_h  = '0;
                    body_h = '0;
                    ph     = ufp_pkg::PH_BODY;
                end
            end
            ufp_pkg::PH_BODY:
            begin
                if (cnt_h < 4'd8)
                    body_h[8 * cnt_h +: 8] = b;
                sum_h = sum_h + b;
                cnt_h = cnt_h + 4'd1;
                if (cnt_h >= len_h)
                begin
                    cnt_h = '0;
                    ph    = ufp_pkg::PH_SUM;
                end
            end
            ufp_pkg::PH_SUM:
            begin
                r.status        = (b != sum_h);
                r.control_code  = ctrl_h;
                r.command_code  = cmd_h;
                r.command_bytes = need_h;
                r.body_length   = len_h;
                r.body_bytes    = body_h;
                r.got_checksum  = b;
                r.calc_checksum = sum_h;
                frames_due.push_back(r);
                clear_frame();
            end
            default:
                clear_frame();
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // generator helpers
    task automatic put_byte(input logic [7:0] b);
        link_ops.push_back('{op: LINK_BYTE, data: b, idx: 2'd0});
        byte_total++;
    endtask

    task automatic put_op(input link_op_t op);
        link_ops.push_back('{op: op, data: 8'd0, idx: 2'd0});
    endtask

    task automatic put_cfg(input logic [1:0] idx, input logic [7:0] val);
        link_ops.push_back('{op: LINK_CFG, data: val, idx: idx});
        case (idx)
            ufp_pkg::REG_MAX_CONTROL: plan_max = val;
            ufp_pkg::REG_STD_CAN:     plan_std = val;
            ufp_pkg::REG_EXT_CAN:     plan_ext = val;
            default: ;
        endcase
    endtask

    task automatic put_frame(input logic [7:0] ctrl, input int len, input bit good);
        logic [7:0] sum;
        logic [7:0] v;
        int         nid;
        nid = (ctrl == plan_std) ? 2 : (ctrl == plan_ext) ? 4 : 1;
        put_byte(ufp_pkg::HDR1);
        put_byte(ufp_pkg::HDR2);
        put_byte(len[7:0]);
        put_byte(ctrl);
        sum = ctrl;
        for (int i = 0; i < nid + len; i++)
        begin
            v = 8'($urandom);
            put_byte(v);
            sum = sum + v;
        end
        if (!good)
            sum = sum + 8'($urandom_range(255, 1));
        put_byte(sum);
    endtask

    task automatic put_random(input int n);
        int         stop;
        int         pick;
        logic [7:0] ctrl;
        logic [7:0] v;
        stop = byte_total + n;
        while (byte_total < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                case ($urandom_range(3))
                    0:       ctrl = plan_std;
                    1:       ctrl = plan_ext;
                    2:       ctrl = 8'($urandom_range(int'(plan_max), 0));
                    default: ctrl = 8'($urandom);
                endcase
                put_frame(ctrl, $urandom_range(MAX_BODY, 1), $urandom_range(3) != 0);
            end
            else if (pick < 80)
            begin
                // broken second header byte
                v = 8'($urandom);
                if (v == ufp_pkg::HDR2)
                    v = 8'h00;
                put_byte(ufp_pkg::HDR1);
                put_byte(v);
            end
            else if (pick < 85)
            begin
                put_byte(ufp_pkg::HDR1);
                put_byte(ufp_pkg::HDR2);
                put_byte($urandom_range(1) ? 8'd0 : 8'($urandom_range(255, MAX_BODY + 1)));
            end
            else if (pick < 90 && plan_max != 8'hFF)
            begin
                put_byte(ufp_pkg::HDR1);
                put_byte(ufp_pkg::HDR2);
                put_byte(8'($urandom_range(MAX_BODY, 1)));
                put_byte(8'($urandom_range(255, int'(plan_max) + 1)));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    put_byte(8'($urandom));
            end
        end
    endtask

    // sender
    always @(negedge clk)
    begin : drive_proc
        link_item_t head;
        logic       nxt_push;
        logic       nxt_we;
        logic [7:0] nxt_byte;
        logic [1:0] nxt_idx;
        logic [7:0] nxt_data;
        nxt_push = 1'b0;
        nxt_we   = 1'b0;
        nxt_byte = rx_byte;
        nxt_idx  = cfg_index;
        nxt_data = cfg_data;
        if (!rst_n)
            ;
        else if (push && !in_taken)
        begin
            nxt_push = 1'b1;
        end
        else if (link_ops.size() != 0)
        begin
            head = link_ops[0];
            case (head.op)
                LINK_BYTE:
                    if (no_idle() || $urandom_range(99) >= 17)
                    begin
                        nxt_push = 1'b1;
                        nxt_byte = head.data;
                        void'(link_ops.pop_front());
                    end
                LINK_STALL:
                begin
                    stall_req <= 1'b1;
                    void'(link_ops.pop_front());
                end
                default:
                    // registers change only with the block drained and settled
                    if (frames_due.size() == 0 && quiet >= SETTLE_CYCLES)
                    begin
                        if (head.op == LINK_CFG)
                        begin
                            nxt_we   = 1'b1;
                            nxt_idx  = head.idx;
                            nxt_data = head.data;
                        end
                        void'(link_ops.pop_front());
                    end
            endcase
        end
        push      <= nxt_push;
        rx_byte   <= nxt_byte;
        cfg_we    <= nxt_we;
        cfg_index <= nxt_idx;
        cfg_data  <= nxt_data;
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (stall_req && !stall_done)
        begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES - 1;
            pop <= 1'b0;
        end
        else
            pop <= no_idle() || ($urandom_range(99) >= 17);
    end

    // monitor: byte transfers feed the parser copy, result transfers are checked
    always @(posedge clk)
    begin
        ufp_pkg::result_t want;
        cyc++;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (quiet < 1000)
                quiet++;
            if (push && !full)
            begin
                in_taken = 1'b1;
                quiet    = 0;
                parse_byte(rx_byte);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ufp_pkg::REG_MAX_CONTROL: cfg_max = cfg_data;
                    ufp_pkg::REG_STD_CAN:     cfg_std = cfg_data;
                    ufp_pkg::REG_EXT_CAN:     cfg_ext = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result with no frame pending: control_code %0h", control_code);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("control_code", 64'(want.control_code),
                                64'(control_code));
                    check_field("command_code", 64'(want.command_code),
                                64'(command_code));
                    check_field("command_bytes", 64'(want.command_bytes),
                                64'(command_bytes));
                    check_field("body_length", 64'(want.body_length),
                                64'(body_length));
                    check_field("body_bytes", want.body_bytes, body_bytes);
                    check_field("got_checksum", 64'(want.got_checksum),
                                64'(got_checksum));
                    check_field("calc_checksum", 64'(want.calc_checksum),
                                64'(calc_checksum));
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        rx_byte   = 8'd0;
        cfg_we    = 1'b0;
        cfg_index = 2'd0;
        cfg_data  = 8'd0;
        pop       = 1'b0;

        // directed: failing header byte is not a new start, bad length, control over max
        put_byte(ufp_pkg::HDR1);
        put_byte(ufp_pkg::HDR1);
        put_byte(ufp_pkg::HDR2);
        put_byte(8'd1);
        put_byte(ufp_pkg::HDR1);
        put_byte(ufp_pkg::HDR2);
        put_byte(8'd0);
        put_byte(ufp_pkg::HDR1);
        put_byte(ufp_pkg::HDR2);
        put_byte(8'd1);
        put_byte(8'd16);
        put_frame(plan_ext, MAX_BODY, 1'b1);
        put_frame(plan_std, 1, 1'b0);

        put_random(150);
        put_op(LINK_DRAIN);
        put_random(150);

        put_cfg(ufp_pkg::REG_MAX_CONTROL, 8'hFF);
        put_cfg(ufp_pkg::REG_STD_CAN, 8'hFF);
        put_cfg(ufp_pkg::REG_EXT_CAN, 8'h00);
        put_op(LINK_STALL);
        put_random(250);

        // equal codes, only control id zero accepted
        put_cfg(ufp_pkg::REG_MAX_CONTROL, 8'h00);
        put_cfg(ufp_pkg::REG_STD_CAN, 8'h00);
        put_cfg(ufp_pkg::REG_EXT_CAN, 8'h00);
        put_random(150);

        put_cfg(REG_UNUSED, 8'($urandom));
        put_cfg(ufp_pkg::REG_MAX_CONTROL, 8'h80);
        put_cfg(ufp_pkg::REG_STD_CAN, 8'h07);
        put_cfg(ufp_pkg::REG_EXT_CAN, 8'h07);
        put_random(200);

        put_cfg(ufp_pkg::REG_MAX_CONTROL, 8'($urandom));
        put_cfg(ufp_pkg::REG_STD_CAN, 8'($urandom_range(int'(plan_max), 0)));
        put_cfg(ufp_pkg::REG_EXT_CAN, 8'($urandom));
        put_random(250);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (link_ops.size() != 0 || push);
        do @(negedge clk); while (frames_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
